### design/edfc_pkg.sv
// ----------------------------------------------------------------------------
// edfc_pkg
// shared types and constants for the extended/double format converter
// ----------------------------------------------------------------------------
`default_nettype none

package edfc_pkg;

  // direction codes carried in tuser
  localparam logic OP_EXT_TO_DBL = 1'b0;
  localparam logic OP_DBL_TO_EXT = 1'b1;

  localparam int unsigned EXT_EXP_W  = 15;
  localparam int unsigned DBL_EXP_W  = 11;
  localparam int unsigned DBL_FRAC_W = 52;
  localparam int unsigned MANT_W     = 64;
  localparam int unsigned LZ_W       = 6;

  localparam logic [EXT_EXP_W-1:0] EXT_EXP_MAX = 15'h7FFF;
  localparam logic [DBL_EXP_W-1:0] DBL_EXP_MAX = 11'h7FF;

  // ext biased exponent window that maps onto a normal double
  // (ext bias 16383 minus double bias 1023)
  localparam logic [EXT_EXP_W-1:0] EXP_REBIAS  = 15'd15360;
  localparam logic [EXT_EXP_W-1:0] EXT_EXP_LO  = 15'd15361;
  localparam logic [EXT_EXP_W-1:0] EXT_EXP_HI  = 15'd17406;

  // shift that puts frac bit 51 at the integer bit position
  localparam logic [LZ_W:0] NORM_BASE = 7'd12;

  // double to extended work carried between the decode and normalize stages
  typedef struct packed {
    logic                  sign;
    logic [DBL_EXP_W-1:0]  exp;
    logic [DBL_FRAC_W-1:0] frac;
    logic                  frac_zero;
    logic [LZ_W-1:0]       lz;
  } d2e_work_t;

endpackage

`default_nettype wire

### design/extended_double_float_convert.sv
// ----------------------------------------------------------------------------
// extended_double_float_convert
// converts between x87 80-bit extended and ieee-754 double, one direction
// chosen per request
// ----------------------------------------------------------------------------
// usage
//   input channel: in_tdata carries the extended operand and the double
//   operand side by side, in_tuser selects the direction (0 = extended to
//   double, 1 = double to extended); the unused operand is ignored
//   output channel: out_tdata carries all three result fields, the ones of
//   the other direction read as zero
//   path: an accepted request passes the input register, decode and
//   leading-zero count, normalize shift and the output register
//   throughput: one request per cycle when not stalled; the three register
//   stages move together, so the rate is set by a single pipeline stage
//   stall: when out_tready is low with a result waiting, the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated
//   reset: rst_n (synchronous, active low) clears the stage valid bits; the
//   block has no other state and no configuration
//   extended to double truncates the fraction, flushes denormal and
//   underflowing values to signed zero, saturates overflow to infinity and
//   keeps a nan a nan; double to extended normalizes denormals
// ----------------------------------------------------------------------------
`default_nettype none

module extended_double_float_convert (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // ext_sign_exponent[15:0], ext_mantissa[79:16], double_bits[143:80]
  input  wire logic [143:0] in_tdata,
  // operation[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // double_result[63:0], ext_sign_exponent_result[79:64],
  // ext_mantissa_result[143:80]
  output logic [143:0]      out_tdata
);

  // output slot valid, drives the global advance
  logic out_valid_r;

  // global advance: every stage moves when the output slot is free or taken
  logic advance;
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [15:0] s1_se_r;
  logic [63:0] s1_mant_r;
  logic [63:0] s1_dbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r   <= in_tuser;
      s1_se_r   <= in_tdata[15:0];
      s1_mant_r <= in_tdata[79:16];
      s1_dbl_r  <= in_tdata[143:80];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 logic: full extended to double, decode and leading-zero count
  // for double to extended
  // --------------------------------------------------------------------------
  logic [edfc_pkg::EXT_EXP_W-1:0]  e2d_exp;
  logic [edfc_pkg::DBL_FRAC_W-1:0] e2d_top_frac;
  logic                            e2d_low_nz;
  logic [63:0]                     e2d_res_nxt;
  logic [edfc_pkg::EXT_EXP_W-1:0]  e2d_rebias;

  assign e2d_exp      = s1_se_r[14:0];
  assign e2d_top_frac = s1_mant_r[62:11];
  assign e2d_low_nz   = |s1_mant_r[62:0];
  assign e2d_rebias   = e2d_exp - edfc_pkg::EXP_REBIAS;

  always_comb begin
    e2d_res_nxt = {s1_se_r[15], 63'd0};
    if (e2d_exp == edfc_pkg::EXT_EXP_MAX) begin
      // inf or nan; a nan whose payload sits only below the kept bits
      // still needs one fraction bit set
      e2d_res_nxt[62:52] = edfc_pkg::DBL_EXP_MAX;
      if (e2d_top_frac == '0 && e2d_low_nz) begin
        e2d_res_nxt[51:0] = 52'd1;
      end else begin
        e2d_res_nxt[51:0] = e2d_top_frac;
      end
    end else if (e2d_exp > edfc_pkg::EXT_EXP_HI) begin
      e2d_res_nxt[62:52] = edfc_pkg::DBL_EXP_MAX;
    end else if (e2d_exp >= edfc_pkg::EXT_EXP_LO) begin
      e2d_res_nxt[62:52] = e2d_rebias[edfc_pkg::DBL_EXP_W-1:0];
      e2d_res_nxt[51:0]  = e2d_top_frac;
    end
    // zero exponent and underflow keep the signed zero
  end

  edfc_pkg::d2e_work_t d2e_nxt;
  logic [edfc_pkg::LZ_W-1:0] lz_cnt;

  // leading zeros of the double fraction, a priority encoder
  always_comb begin
    lz_cnt = '0;
    for (int i = 0; i < edfc_pkg::DBL_FRAC_W; i++) begin
      if (s1_dbl_r[i]) begin
        lz_cnt = edfc_pkg::LZ_W'(edfc_pkg::DBL_FRAC_W - 1 - i);
      end
    end
  end

  always_comb begin
    d2e_nxt.sign      = s1_dbl_r[63];
    d2e_nxt.exp       = s1_dbl_r[62:52];
    d2e_nxt.frac      = s1_dbl_r[51:0];
    d2e_nxt.frac_zero = ~|s1_dbl_r[51:0];
    d2e_nxt.lz        = lz_cnt;
  end

  // --------------------------------------------------------------------------
  // stage 2 register
  // --------------------------------------------------------------------------
  logic                s2_valid_r;
  logic                s2_op_r;
  logic [63:0]         s2_e2d_r;
  edfc_pkg::d2e_work_t s2_d2e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op_r  <= s1_op_r;
      s2_e2d_r <= e2d_res_nxt;
      s2_d2e_r <= d2e_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 logic: normalize shift for double to extended, result select
  // --------------------------------------------------------------------------
  logic [edfc_pkg::LZ_W:0]        norm_shift;
  logic [63:0]                    denorm_mant;
  logic [edfc_pkg::EXT_EXP_W-1:0] denorm_exp;
  logic [edfc_pkg::EXT_EXP_W-1:0] normal_exp;
  logic [15:0]                    d2e_se;
  logic [63:0]                    d2e_mant;
  logic [143:0]                   out_data_nxt;

  assign norm_shift  = edfc_pkg::NORM_BASE + {1'b0, s2_d2e_r.lz};
  assign denorm_mant = {12'd0, s2_d2e_r.frac} << norm_shift;
  assign denorm_exp  = edfc_pkg::EXP_REBIAS
                     - {{(edfc_pkg::EXT_EXP_W-edfc_pkg::LZ_W){1'b0}}, s2_d2e_r.lz};
  assign normal_exp  = edfc_pkg::EXP_REBIAS
                     + {{(edfc_pkg::EXT_EXP_W-edfc_pkg::DBL_EXP_W){1'b0}}, s2_d2e_r.exp};

  always_comb begin
    d2e_se   = {s2_d2e_r.sign, 15'd0};
    d2e_mant = {1'b1, s2_d2e_r.frac, 11'd0};
    if (s2_d2e_r.exp == '0) begin
      if (s2_d2e_r.frac_zero) begin
        d2e_mant = '0;
      end else begin
        d2e_se[14:0] = denorm_exp;
        d2e_mant     = denorm_mant;
      end
    end else if (s2_d2e_r.exp == edfc_pkg::DBL_EXP_MAX) begin
      d2e_se[14:0] = edfc_pkg::EXT_EXP_MAX;
    end else begin
      d2e_se[14:0] = normal_exp;
    end
  end

  always_comb begin
    if (s2_op_r == edfc_pkg::OP_DBL_TO_EXT) begin
      out_data_nxt = {d2e_mant, d2e_se, 64'd0};
    end else begin
      out_data_nxt = {64'd0, 16'd0, s2_e2d_r};
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: output register
  // --------------------------------------------------------------------------
  logic [143:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### tb/sv/edfc_conversion_checker.sv
// ----------------------------------------------------------------------------
// edfc_conversion_checker
// watches both stream channels of the format converter, predicts the
// converted operand for every accepted request and compares each result
// field against the oldest prediction
// ----------------------------------------------------------------------------

module edfc_conversion_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [143:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [143:0] out_tdata,
  output int unsigned       fail_count,
  output int unsigned       pending_count
);

  localparam int EXT_BIAS    = 16383;
  localparam int DBL_BIAS    = 1023;
  localparam int DBL_MIN_EXP = -1022;

  // same field order as out_tdata, lowest field last
  typedef struct packed {
    logic [63:0] ext_mantissa_result;
    logic [15:0] ext_sign_exponent_result;
    logic [63:0] double_result;
  } conv_result_t;

  conv_result_t expected_results[$];
  conv_result_t want;
  conv_result_t got;

  function automatic conv_result_t predict_conversion(input logic op,
                                                      input logic [143:0] data);
    conv_result_t res;
    logic [15:0]  se;
    logic [63:0]  mant;
    logic [63:0]  dbits;
    logic [51:0]  frac;
    logic         sgn;
    int           unb;
    int           lead;
    se    = data[15:0];
    mant  = data[79:16];
    dbits = data[143:80];
    res   = '0;
    if (op == edfc_pkg::OP_EXT_TO_DBL) begin
      // integer bit is not looked at, so unnormals convert like normals
      sgn  = se[15];
      unb  = int'(se[14:0]) - EXT_BIAS;
      frac = mant[62:11];
      if (se[14:0] == '0) begin
        res.double_result = {sgn, 63'd0};
      end else if (se[14:0] == edfc_pkg::EXT_EXP_MAX) begin
        // payload only below the kept bits must still leave a nan
        if (frac == '0 && mant[62:0] != '0) frac = 52'd1;
        res.double_result = {sgn, edfc_pkg::DBL_EXP_MAX, frac};
      end else if (unb > DBL_BIAS) begin
        res.double_result = {sgn, edfc_pkg::DBL_EXP_MAX, 52'd0};
      end else if (unb < DBL_MIN_EXP) begin
        res.double_result = {sgn, 63'd0};
      end else begin
        res.double_result = {sgn, 11'(unb + DBL_BIAS), frac};
      end
    end else begin
      sgn  = dbits[63];
      frac = dbits[51:0];
      if (dbits[62:52] == '0) begin
        if (frac == '0) begin
          res.ext_sign_exponent_result = {sgn, 15'd0};
        end else begin
          // denormal: find the leading one and move it to the integer bit
          lead = 51;
          while (lead > 0 && !frac[lead]) lead--;
          res.ext_sign_exponent_result = {sgn, 15'(DBL_MIN_EXP - (52 - lead) + EXT_BIAS)};
          res.ext_mantissa_result      = 64'(frac) << (63 - lead);
        end
      end else if (dbits[62:52] == edfc_pkg::DBL_EXP_MAX) begin
        res.ext_sign_exponent_result = {sgn, edfc_pkg::EXT_EXP_MAX};
        res.ext_mantissa_result      = {1'b1, frac, 11'd0};
      end else begin
        res.ext_sign_exponent_result = {sgn, 15'(int'(dbits[62:52]) - DBL_BIAS + EXT_BIAS)};
        res.ext_mantissa_result      = {1'b1, frac, 11'd0};
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_conversion(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $error("result %h with no request outstanding", out_tdata);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.double_result !== want.double_result) begin
            $error("double_result expected %h actual %h",
                   want.double_result, got.double_result);
            fail_count = fail_count + 1;
          end
          if (got.ext_sign_exponent_result !== want.ext_sign_exponent_result) begin
            $error("ext_sign_exponent_result expected %h actual %h",
                   want.ext_sign_exponent_result, got.ext_sign_exponent_result);
            fail_count = fail_count + 1;
          end
          if (got.ext_mantissa_result !== want.ext_mantissa_result) begin
            $error("ext_mantissa_result expected %h actual %h",
                   want.ext_mantissa_result, got.ext_mantissa_result);
            fail_count = fail_count + 1;
          end
        end
      end
      pending_count = expected_results.size();
    end
  end

endmodule

### tb/sv/extended_double_float_convert_test.sv
// ----------------------------------------------------------------------------
// extended_double_float_convert_test
// drives directed corner operands and random requests in both directions
// through the converter under four idle/stall regimes; a checker beside the
// block predicts and compares every result
// ----------------------------------------------------------------------------

module extended_double_float_convert_test;

  localparam int EXT_BIAS         = 16383;
  localparam int DBL_BIAS         = 1023;
  localparam int RANDOM_PER_PHASE = 288;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 8;

  // idle and stall chance per phase: none, sender, receiver, both
  localparam int SENDER_IDLE_PCT[4]    = '{0, 68, 0, 23};
  localparam int RECEIVER_STALL_PCT[4] = '{0, 0, 68, 23};

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // ext_sign_exponent[15:0], ext_mantissa[79:16], double_bits[143:80]
  logic [143:0] in_tdata;
  // operation[0]
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // double_result[63:0], ext_sign_exponent_result[79:64],
  // ext_mantissa_result[143:80]
  logic [143:0] out_tdata;

  int unsigned  fail_count;
  int unsigned  pending_count;
  int unsigned  cycle_count;
  int           sender_idle_pct;
  int           receiver_stall_pct;

  extended_double_float_convert uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  edfc_conversion_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: ready drops at random with the current phase's stall chance
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // run limit, far above the slowest correct run; the counter starts at zero
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // one request, held until accepted; idle gaps come before it
  task automatic send_request(input logic op, input logic [15:0] se,
                              input logic [63:0] mant, input logic [63:0] dbits);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dbits, mant, se};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // the other direction's operand is filled with noise, it must be ignored
  task automatic send_ext(input logic [15:0] se, input logic [63:0] mant);
    send_request(edfc_pkg::OP_EXT_TO_DBL, se, mant, wide_random());
  endtask

  task automatic send_dbl(input logic [63:0] dbits);
    send_request(edfc_pkg::OP_DBL_TO_EXT, 16'($urandom), wide_random(), dbits);
  endtask

  initial begin
    logic [14:0] ext_exp;
    logic [63:0] mant;
    logic [10:0] dbl_exp;
    logic [51:0] frac;

    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    in_tuser           = edfc_pkg::OP_EXT_TO_DBL;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extended to double corners
    send_ext(16'h0000, 64'h0000_0000_0000_0000);  // positive zero
    send_ext(16'h8000, 64'h0000_1234_5678_9abc);  // denormal flushes to signed zero
    send_ext(16'h0001, 64'h8000_0000_0000_0000);  // smallest exponent, underflow
    send_ext(16'h3c00, 64'hffff_ffff_ffff_ffff);  // one below the double range
    send_ext(16'h3c01, 64'hffff_ffff_ffff_ffff);  // smallest normal double
    send_ext(16'hc3fe, 64'hffff_ffff_ffff_ffff);  // largest normal double, negative
    send_ext(16'h43ff, 64'h8000_0000_0000_0000);  // one above, saturates to infinity
    send_ext(16'h7ffe, 64'hffff_ffff_ffff_ffff);  // largest finite extended
    send_ext(16'h7fff, 64'h8000_0000_0000_0000);  // infinity
    send_ext(16'h7fff, 64'h0000_0000_0000_0000);  // pseudo-infinity
    send_ext(16'hffff, 64'hffff_ffff_ffff_ffff);  // negative nan, full payload
    send_ext(16'h7fff, 64'h8000_0000_0000_0400);  // nan payload only below kept bits
    send_ext(16'h7fff, 64'h0000_0000_0000_0001);  // nan, integer bit clear
    send_ext(16'h3fff, 64'h4000_0000_0000_0000);  // unnormal, integer bit ignored
    send_ext(16'h3fff, 64'h8000_0000_0000_0000);  // one
    // double to extended corners
    send_dbl(64'h0000_0000_0000_0000);            // positive zero
    send_dbl(64'h8000_0000_0000_0000);            // negative zero
    send_dbl(64'h0000_0000_0000_0001);            // smallest denormal
    send_dbl(64'h000f_ffff_ffff_ffff);            // largest denormal
    send_dbl(64'h8008_0000_0000_0000);            // negative denormal, top frac bit
    send_dbl(64'h0010_0000_0000_0000);            // smallest normal
    send_dbl(64'h7fef_ffff_ffff_ffff);            // largest normal
    send_dbl(64'h7ff0_0000_0000_0000);            // infinity
    send_dbl(64'hfff8_0000_0000_0001);            // negative nan with payload
    send_dbl(64'h3ff0_0000_0000_0000);            // one

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = SENDER_IDLE_PCT[phase];
      receiver_stall_pct = RECEIVER_STALL_PCT[phase];
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(1) == 0) begin
          // exponent weighted toward the special codes and range edges
          case ($urandom_range(9))
            0:       ext_exp = '0;
            1:       ext_exp = edfc_pkg::EXT_EXP_MAX;
            2, 3:    ext_exp = 15'(EXT_BIAS - DBL_BIAS + 1 + $urandom_range(2045));
            4:       ext_exp = 15'(EXT_BIAS - DBL_BIAS - 4 + $urandom_range(8));
            5:       ext_exp = 15'(EXT_BIAS + DBL_BIAS - 4 + $urandom_range(8));
            6:       ext_exp = 15'($urandom_range(1, 20));
            7:       ext_exp = edfc_pkg::EXT_EXP_MAX - 15'($urandom_range(1, 20));
            default: ext_exp = 15'($urandom);
          endcase
          // mantissa: sparse payloads, single bits, solid patterns, noise
          case ($urandom_range(5))
            0:       mant = wide_random() & ((64'd1 << $urandom_range(12)) - 64'd1);
            1:       mant = 64'd1 << $urandom_range(63);
            2:       mant = $urandom_range(1) ? '1 : '0;
            default: mant = wide_random();
          endcase
          if ($urandom_range(3) == 0) mant[63] = ~mant[63];
          send_ext({1'($urandom), ext_exp}, mant);
        end else begin
          case ($urandom_range(7))
            0, 1:    dbl_exp = '0;
            2:       dbl_exp = edfc_pkg::DBL_EXP_MAX;
            3:       dbl_exp = $urandom_range(1) ? 11'd1 : edfc_pkg::DBL_EXP_MAX - 11'd1;
            default: dbl_exp = 11'($urandom);
          endcase
          // a random right shift walks the leading one over every position
          case ($urandom_range(3))
            0:       frac = '0;
            1:       frac = 52'(wide_random() >> $urandom_range(12, 63));
            default: frac = 52'(wide_random());
          endcase
          send_dbl({1'($urandom), dbl_exp, frac});
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
